FILE: design/e2c_pkg.sv
// constants, reciprocal factors and the month start table for the epoch to calendar unit
// standalone package, no dependencies

package e2c_pkg;

    localparam int unsigned STAMP_W = 32;
    localparam int unsigned OUT_W   = 48;

    // exact constant division by multiply and shift: x / d = (x * K) >> S
    localparam int unsigned DIV15_S   = 34;   // input up to 30 bits
    localparam logic [30:0] DIV15_K   = 31'((64'd1 << DIV15_S) / 64'd15 + 64'd1);
    localparam int unsigned DIV3_S    = 20;   // input up to 18 bits
    localparam logic [18:0] DIV3_K    = 19'((64'd1 << DIV3_S) / 64'd3 + 64'd1);
    localparam int unsigned DIV7_S    = 19;   // input up to 16 bits
    localparam logic [16:0] DIV7_K    = 17'((64'd1 << DIV7_S) / 64'd7 + 64'd1);
    localparam int unsigned DIV1461_S = 27;   // input up to 16 bits
    localparam logic [16:0] DIV1461_K = 17'((64'd1 << DIV1461_S) / 64'd1461 + 64'd1);

    // days are counted from 1968-01-01 so that four year cycles start on a leap year
    localparam logic [15:0] DAYS_1968_TO_1970 = 16'd731;
    localparam logic [10:0] DAYS_PER_CYCLE    = 11'd1461;
    // first day after the missing leap day of 2100, counted from 1970-01-01
    localparam logic [15:0] DAY_2100_MAR_1    = 16'd47541;
    localparam logic [7:0]  YEAR_1968_OFFSET  = 8'd68;
    localparam logic [7:0]  YEAR_2100_OFFSET  = 8'd200;
    localparam logic [3:0]  THURSDAY          = 4'd4;

    localparam logic [10:0] YEAR1_START = 11'd366;
    localparam logic [10:0] YEAR2_START = 11'd731;
    localparam logic [10:0] YEAR3_START = 11'd1096;

    typedef struct packed {
        logic [4:0] day_of_month;
        logic [3:0] month_index;
        logic [8:0] day_of_year;
        logic [7:0] years_since_1900;
        logic [2:0] weekday;
        logic [4:0] hour;
        logic [5:0] minute;
        logic [5:0] second;
    } cal_fields_t;

    // day of year on which a month starts
    function automatic logic [8:0] month_start(input logic [3:0] mon, input logic leap);
        logic [8:0] base;
        unique case (mon)
            4'd0:    base = 9'd0;
            4'd1:    base = 9'd31;
            4'd2:    base = 9'd59;
            4'd3:    base = 9'd90;
            4'd4:    base = 9'd120;
            4'd5:    base = 9'd151;
            4'd6:    base = 9'd181;
            4'd7:    base = 9'd212;
            4'd8:    base = 9'd243;
            4'd9:    base = 9'd273;
            4'd10:   base = 9'd304;
            4'd11:   base = 9'd334;
            default: base = 9'd0;
        endcase
        return base + ((leap && mon >= 4'd2) ? 9'd1 : 9'd0);
    endfunction

endpackage

FILE: design/epoch_seconds_to_calendar_unit.sv
// unix seconds to utc calendar fields, seven stage pipeline
// uses e2c_pkg for reciprocal constants, the month table and the result layout
//
// throughput: one request per cycle while the output is not stalled; a full stage holds while its successor cannot load
// a stalled output still lets requests in until the pipeline bubbles are used up
// reset: rst_n asynchronous active low, clears all stage valid bits; data regs not reset

module epoch_seconds_to_calendar_unit (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [e2c_pkg::STAMP_W-1:0] s_axis_tdata,  // [31:0] seconds_since_epoch
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    // [5:0] second, [11:6] minute, [16:12] hour, [19:17] weekday,
    // [27:20] years_since_1900, [36:28] day_of_year, [40:37] month_index,
    // [45:41] day_of_month, [47:46] zero
    output logic [e2c_pkg::OUT_W-1:0]   m_axis_tdata
);
    import e2c_pkg::*;

    localparam int unsigned NSTAGE = 7;

    logic [NSTAGE-1:0] v_reg;
    logic [NSTAGE-1:0] rdy;

    // stage 1
    logic [31:0] s1_stamp_reg;
    logic [60:0] s1_prod_reg;
    // stage 2
    logic [5:0]  s2_sec_reg;
    logic [26:0] s2_mins_reg;
    logic [55:0] s2_prod_reg;
    // stage 3
    logic [5:0]  s3_sec_reg,  s3_min_reg;
    logic [20:0] s3_hours_reg;
    logic [36:0] s3_prod_reg;
    // stage 4
    logic [5:0]  s4_sec_reg,  s4_min_reg;
    logic [4:0]  s4_hour_reg;
    logic [15:0] s4_days_reg;
    // stage 5
    logic [5:0]  s5_sec_reg,  s5_min_reg;
    logic [4:0]  s5_hour_reg;
    logic        s5_adj_reg;
    logic [15:0] s5_dp_reg;
    logic [15:0] s5_wx_reg;
    logic [32:0] s5_wprod_reg;
    logic [32:0] s5_cprod_reg;
    // stage 6
    logic [5:0]  s6_sec_reg,  s6_min_reg;
    logic [4:0]  s6_hour_reg;
    logic [2:0]  s6_wday_reg;
    logic        s6_adj_reg;
    logic        s6_leap_reg;
    logic [7:0]  s6_year_reg;
    logic [8:0]  s6_yday_reg;
    // stage 7
    cal_fields_t out_reg;

    // handshake chain: a stage loads when empty or when its contents move on
    always_comb
    begin
        rdy[NSTAGE-1] = !v_reg[NSTAGE-1] || m_axis_tready;
        for (int k = NSTAGE - 2; k >= 0; k--)
        begin
            rdy[k] = !v_reg[k] || rdy[k+1];
        end
    end

    assign s_axis_tready = rdy[0];
    assign m_axis_tvalid = v_reg[NSTAGE-1];
    assign m_axis_tdata  = {{(OUT_W - $bits(cal_fields_t)){1'b0}}, out_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (rdy[0])
            begin
                v_reg[0] <= s_axis_tvalid;
            end
            for (int k = 1; k < NSTAGE; k++)
            begin
                if (rdy[k])
                begin
                    v_reg[k] <= v_reg[k-1];
                end
            end
        end
    end

    // stage 1: minutes = (stamp / 4) / 15
    always_ff @(posedge clk)
    begin
        if (rdy[0] && s_axis_tvalid)
        begin
            s1_stamp_reg <= s_axis_tdata;
            s1_prod_reg  <= s_axis_tdata[31:2] * DIV15_K;
        end
    end

    // stage 2: seconds, and hours = (minutes / 4) / 15
    logic [26:0] s2_mins_next;
    logic [31:0] s2_m60;
    assign s2_mins_next = s1_prod_reg[60:DIV15_S];
    assign s2_m60 = ({5'd0, s2_mins_next} << 6) - ({5'd0, s2_mins_next} << 2);

    always_ff @(posedge clk)
    begin
        if (rdy[1] && v_reg[0])
        begin
            s2_sec_reg  <= 6'(s1_stamp_reg - s2_m60);
            s2_mins_reg <= s2_mins_next;
            s2_prod_reg <= s2_mins_next[26:2] * DIV15_K;
        end
    end

    // stage 3: minute, and days = (hours / 8) / 3
    logic [20:0] s3_hours_next;
    logic [26:0] s3_h60;
    assign s3_hours_next = s2_prod_reg[54:DIV15_S];
    assign s3_h60 = ({6'd0, s3_hours_next} << 6) - ({6'd0, s3_hours_next} << 2);

    always_ff @(posedge clk)
    begin
        if (rdy[2] && v_reg[1])
        begin
            s3_sec_reg   <= s2_sec_reg;
            s3_min_reg   <= 6'(s2_mins_reg - s3_h60);
            s3_hours_reg <= s3_hours_next;
            s3_prod_reg  <= s3_hours_next[20:3] * DIV3_K;
        end
    end

    // stage 4: hour and whole days
    logic [15:0] s4_days_next;
    logic [20:0] s4_d24;
    assign s4_days_next = s3_prod_reg[35:DIV3_S];
    assign s4_d24 = ({5'd0, s4_days_next} << 4) + ({5'd0, s4_days_next} << 3);

    always_ff @(posedge clk)
    begin
        if (rdy[3] && v_reg[2])
        begin
            s4_sec_reg  <= s3_sec_reg;
            s4_min_reg  <= s3_min_reg;
            s4_hour_reg <= 5'(s3_hours_reg - s4_d24);
            s4_days_reg <= s4_days_next;
        end
    end

    // stage 5: rebase days to 1968, insert a phantom 29 feb 2100 so every
    // four year cycle is regular, start the weekday and cycle divisions
    logic        s5_adj_next;
    logic [15:0] s5_dp_next;
    logic [15:0] s5_wx_next;
    assign s5_adj_next = (s4_days_reg >= DAY_2100_MAR_1);
    assign s5_dp_next  = s4_days_reg + DAYS_1968_TO_1970 + {15'd0, s5_adj_next};
    assign s5_wx_next  = s4_days_reg + {12'd0, THURSDAY};

    always_ff @(posedge clk)
    begin
        if (rdy[4] && v_reg[3])
        begin
            s5_sec_reg   <= s4_sec_reg;
            s5_min_reg   <= s4_min_reg;
            s5_hour_reg  <= s4_hour_reg;
            s5_adj_reg   <= s5_adj_next;
            s5_dp_reg    <= s5_dp_next;
            s5_wx_reg    <= s5_wx_next;
            s5_wprod_reg <= s5_wx_next * DIV7_K;
            s5_cprod_reg <= s5_dp_next * DIV1461_K;
        end
    end

    // stage 6: weekday, year within the cycle, day of year in the padded calendar
    logic [13:0] s6_wq;
    logic [15:0] s6_wq7;
    logic [5:0]  s6_cyc;
    logic [10:0] s6_rem;
    logic [1:0]  s6_yoff;
    logic [10:0] s6_ystart;
    logic [7:0]  s6_year_next;
    assign s6_wq  = s5_wprod_reg[32:DIV7_S];
    assign s6_wq7 = ({2'd0, s6_wq} << 3) - {2'd0, s6_wq};
    assign s6_cyc = s5_cprod_reg[32:DIV1461_S];
    assign s6_rem = 11'(s5_dp_reg - 16'(s6_cyc) * 16'(DAYS_PER_CYCLE));
    assign s6_year_next = YEAR_1968_OFFSET + {s6_cyc, 2'b00} + {6'd0, s6_yoff};

    always_comb
    begin
        priority if (s6_rem >= YEAR3_START)
        begin
            s6_yoff   = 2'd3;
            s6_ystart = YEAR3_START;
        end
        else if (s6_rem >= YEAR2_START)
        begin
            s6_yoff   = 2'd2;
            s6_ystart = YEAR2_START;
        end
        else if (s6_rem >= YEAR1_START)
        begin
            s6_yoff   = 2'd1;
            s6_ystart = YEAR1_START;
        end
        else
        begin
            s6_yoff   = 2'd0;
            s6_ystart = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy[5] && v_reg[4])
        begin
            s6_sec_reg  <= s5_sec_reg;
            s6_min_reg  <= s5_min_reg;
            s6_hour_reg <= s5_hour_reg;
            s6_wday_reg <= 3'(s5_wx_reg - s6_wq7);
            // the phantom day only shifts the day of year within 2100 itself
            s6_adj_reg  <= s5_adj_reg && (s6_year_next == YEAR_2100_OFFSET);
            s6_leap_reg <= (s6_yoff == 2'd0);
            s6_year_reg <= s6_year_next;
            s6_yday_reg <= 9'(s6_rem - s6_ystart);
        end
    end

    // stage 7: month lookup on the padded calendar, true day of year
    logic [3:0] s7_mon;
    logic [8:0] s7_mstart;
    always_comb
    begin
        s7_mon    = '0;
        s7_mstart = '0;
        for (int m = 0; m < 12; m++)
        begin
            if (month_start(4'(m), s6_leap_reg) <= s6_yday_reg)
            begin
                s7_mon    = 4'(m);
                s7_mstart = month_start(4'(m), s6_leap_reg);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy[6] && v_reg[5])
        begin
            out_reg.second           <= s6_sec_reg;
            out_reg.minute           <= s6_min_reg;
            out_reg.hour             <= s6_hour_reg;
            out_reg.weekday          <= s6_wday_reg;
            out_reg.years_since_1900 <= s6_year_reg;
            out_reg.day_of_year      <= s6_yday_reg - {8'd0, s6_adj_reg};
            out_reg.month_index      <= s7_mon;
            out_reg.day_of_month     <= 5'(s6_yday_reg - s7_mstart + 9'd1);
        end
    end

endmodule

FILE: verif/tb.sv
// self-checking bench for epoch_seconds_to_calendar_unit: directed table then random timestamps
// predicts the gmtime-style breakdown locally and checks every result, in order, field by field
// depends on e2c_pkg for the stream widths and the calendar result layout

module tb;

    import e2c_pkg::*;

    localparam int unsigned SECS_PER_DAY  = 86400;
    localparam int unsigned LAST_FULL_DAY = 49709;   // 2106-02-06, last day that fits whole
    localparam int unsigned RANDOM_ITEMS  = 1526;
    localparam int unsigned QUIET_FROM    = 1300;
    localparam int unsigned BURST_FROM    = 40;      // no sender gaps while the output is held
    localparam int unsigned LONG_HOLD     = 80;
    localparam int unsigned DRAIN_CYCLES  = 20;
    localparam int unsigned MAX_REPORTS   = 40;

    localparam int unsigned MONTH_FIRST_DAY [12] =
        '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334};

    typedef struct {
        logic [STAMP_W-1:0] stamp;
        bit                 typed;
        cal_fields_t        want;
    } stamp_case_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               s_axis_tvalid = 1'b0;
    logic               s_axis_tready;
    logic [STAMP_W-1:0] s_axis_tdata = '0;
    logic               m_axis_tvalid;
    logic               m_axis_tready = 1'b0;
    logic [OUT_W-1:0]   m_axis_tdata;

    cal_fields_t   calendar_due [$];
    stamp_case_t   directed_cases [$];
    int unsigned   mismatches = 0;
    bit            long_hold_req = 1'b0;
    bit            quiet_tail = 1'b0;

    epoch_seconds_to_calendar_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),   // [31:0] seconds_since_epoch
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        // [5:0] second, [11:6] minute, [16:12] hour, [19:17] weekday,
        // [27:20] years_since_1900, [36:28] day_of_year, [40:37] month_index,
        // [45:41] day_of_month, [47:46] zero
        .m_axis_tdata  (m_axis_tdata)
    );

    always #5 clk = ~clk;

    function automatic bit is_leap(input int unsigned yr);
        return (yr % 4 == 0) && ((yr % 100 != 0) || (yr % 400 == 0));
    endfunction

    function automatic int unsigned year_days(input int unsigned yr);
        return is_leap(yr) ? 366 : 365;
    endfunction

    // gmtime-style breakdown of an unsigned 32-bit epoch count
    function automatic cal_fields_t break_down_stamp(input logic [STAMP_W-1:0] stamp);
        cal_fields_t f;
        int unsigned rest;
        int unsigned days;
        int unsigned yr;
        int unsigned mon;
        int unsigned first;
        int unsigned s;
        bit          leap;
        f.second  = 6'(stamp % 60);
        rest      = stamp / 60;
        f.minute  = 6'(rest % 60);
        rest      = rest / 60;
        f.hour    = 5'(rest % 24);
        days      = rest / 24;
        f.weekday = 3'((days + 4) % 7);
        yr = 1970;
        while (days >= year_days(yr))
        begin
            days = days - year_days(yr);
            yr++;
        end
        f.years_since_1900 = 8'(yr - 1900);
        f.day_of_year      = 9'(days);
        leap  = is_leap(yr);
        mon   = 0;
        first = 0;
        for (int unsigned m = 0; m < 12; m++)
        begin
            s = MONTH_FIRST_DAY[m] + ((leap && m >= 2) ? 1 : 0);
            if (s <= days)
            begin
                mon   = m;
                first = s;
            end
        end
        f.month_index  = 4'(mon);
        f.day_of_month = 5'(days - first + 1);
        return f;
    endfunction

    function automatic cal_fields_t calendar_fields(
        input int unsigned yr, input int unsigned yday, input int unsigned mon,
        input int unsigned mday, input int unsigned wday, input int unsigned hr,
        input int unsigned mi, input int unsigned sc);
        cal_fields_t f;
        f.years_since_1900 = 8'(yr);
        f.day_of_year      = 9'(yday);
        f.month_index      = 4'(mon);
        f.day_of_month     = 5'(mday);
        f.weekday          = 3'(wday);
        f.hour             = 5'(hr);
        f.minute           = 6'(mi);
        f.second           = 6'(sc);
        return f;
    endfunction

    // offer one request and log its expected result once it is taken
    task automatic offer_stamp(input logic [STAMP_W-1:0] stamp, input cal_fields_t want);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= stamp;
        do
            @(posedge clk);
        while (!s_axis_tready);
        calendar_due.push_back(want);
    endtask

    task automatic idle_input(input int unsigned cycles);
        s_axis_tvalid <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        wait (calendar_due.size() == 0);
        @(posedge clk);
    endtask

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (got !== want)
        begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
        end
    endtask

    always @(posedge clk)
    begin : result_check
        cal_fields_t got;
        cal_fields_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = cal_fields_t'(m_axis_tdata[45:0]);
            if (calendar_due.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("%0t: result expected none actual %h", $time, m_axis_tdata);
            end
            else
            begin
                want = calendar_due.pop_front();
                compare_field("second", 32'(want.second), 32'(got.second));
                compare_field("minute", 32'(want.minute), 32'(got.minute));
                compare_field("hour", 32'(want.hour), 32'(got.hour));
                compare_field("weekday", 32'(want.weekday), 32'(got.weekday));
                compare_field("years_since_1900", 32'(want.years_since_1900),
                              32'(got.years_since_1900));
                compare_field("day_of_year", 32'(want.day_of_year), 32'(got.day_of_year));
                compare_field("month_index", 32'(want.month_index), 32'(got.month_index));
                compare_field("day_of_month", 32'(want.day_of_month), 32'(got.day_of_month));
                compare_field("padding", 32'd0, 32'(m_axis_tdata[47:46]));
            end
        end
    end

    // output side: random back-pressure bursts, one long hold-off on request
    initial
    begin : result_drain
        wait (rst_n);
        forever
        begin
            if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end
            else if (!quiet_tail && $urandom_range(0, 3) == 0)
            begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge clk);
            end
            else
            begin
                m_axis_tready <= 1'b1;
                repeat ($urandom_range(1, 20)) @(posedge clk);
            end
        end
    end

    initial
    begin : stimulus
        logic [STAMP_W-1:0] stamp;
        int unsigned        yr;
        int unsigned        day_count;

        // midnight edges, leap days, year ends, the 2038 sign bit and the last stamp
        directed_cases.push_back('{32'd0, 1'b1, calendar_fields(70, 0, 0, 1, 4, 0, 0, 0)});
        directed_cases.push_back('{32'd59, 1'b1, calendar_fields(70, 0, 0, 1, 4, 0, 0, 59)});
        directed_cases.push_back('{32'd60, 1'b1, calendar_fields(70, 0, 0, 1, 4, 0, 1, 0)});
        directed_cases.push_back('{32'd3599, 1'b1, calendar_fields(70, 0, 0, 1, 4, 0, 59, 59)});
        directed_cases.push_back('{32'd3600, 1'b1, calendar_fields(70, 0, 0, 1, 4, 1, 0, 0)});
        directed_cases.push_back('{32'd86399, 1'b1,
                                   calendar_fields(70, 0, 0, 1, 4, 23, 59, 59)});
        directed_cases.push_back('{32'd86400, 1'b1, calendar_fields(70, 1, 0, 2, 5, 0, 0, 0)});
        directed_cases.push_back('{32'hFFFF_FFFF, 1'b1,
                                   calendar_fields(206, 37, 1, 7, 0, 6, 28, 15)});
        directed_cases.push_back('{32'd31535999, 1'b0, '0});
        directed_cases.push_back('{32'd31536000, 1'b0, '0});
        directed_cases.push_back('{32'd68169600, 1'b0, '0});
        directed_cases.push_back('{32'd94694399, 1'b0, '0});
        directed_cases.push_back('{32'd946684799, 1'b0, '0});
        directed_cases.push_back('{32'd946684800, 1'b0, '0});
        directed_cases.push_back('{32'd951782400, 1'b0, '0});
        directed_cases.push_back('{32'd951868799, 1'b0, '0});
        directed_cases.push_back('{32'd978307199, 1'b0, '0});
        directed_cases.push_back('{32'd2147483647, 1'b0, '0});
        directed_cases.push_back('{32'd2147483648, 1'b0, '0});
        directed_cases.push_back('{32'd4102444800, 1'b0, '0});
        directed_cases.push_back('{32'd4107542399, 1'b0, '0});
        directed_cases.push_back('{32'd4107542400, 1'b0, '0});
        directed_cases.push_back('{32'hAAAA_AAAA, 1'b0, '0});
        directed_cases.push_back('{32'h5555_5555, 1'b0, '0});

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_cases[k])
        begin
            if ($urandom_range(0, 3) == 0)
                idle_input($urandom_range(1, 15));
            offer_stamp(directed_cases[k].stamp,
                        directed_cases[k].typed ? directed_cases[k].want
                                                : break_down_stamp(directed_cases[k].stamp));
        end

        // let the pipeline empty, then hold the output while requests keep coming
        drain_results();
        long_hold_req = 1'b1;

        for (int unsigned i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i == QUIET_FROM)
                quiet_tail = 1'b1;
            if (i == RANDOM_ITEMS / 2)
                drain_results();
            case ($urandom_range(0, 5))
                0, 1, 2:
                    stamp = $urandom;
                3:
                begin
                    // either side of midnight
                    day_count = $urandom_range(0, LAST_FULL_DAY);
                    stamp = 32'(day_count) * 32'(SECS_PER_DAY);
                    if ($urandom_range(0, 1) == 0)
                        stamp = stamp + $urandom_range(0, 2);
                    else
                        stamp = stamp + SECS_PER_DAY - 1 - $urandom_range(0, 2);
                end
                4:
                begin
                    // either side of new year or of the end of february, century years included
                    yr = $urandom_range(1971, 2106);
                    day_count = 0;
                    for (int unsigned y = 1970; y < yr; y++)
                        day_count += year_days(y);
                    if ($urandom_range(0, 1) == 0)
                        day_count += 59 + $urandom_range(0, 1);   // round the end of february
                    stamp = 32'(day_count) * 32'(SECS_PER_DAY) - 2 + $urandom_range(0, 4);
                end
                default:
                begin
                    if ($urandom_range(0, 1) == 0)
                        stamp = $urandom_range(0, 200000000);
                    else
                        stamp = 32'hFFFF_FFFF - $urandom_range(0, 100000000);
                end
            endcase
            if (!quiet_tail && i >= BURST_FROM && $urandom_range(0, 3) == 0)
                idle_input($urandom_range(1, 15));
            offer_stamp(stamp, break_down_stamp(stamp));
        end

        drain_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && calendar_due.size() == 0)
            $display("epoch_seconds_to_calendar_unit verification clean");
        else
            $display("epoch_seconds_to_calendar_unit verification failed");
        $finish;
    end

    initial
    begin : watchdog
        #4000000;
        $display("epoch_seconds_to_calendar_unit verification failed");
        $finish;
    end

endmodule

FILE: filelist.f
design/e2c_pkg.sv
design/epoch_seconds_to_calendar_unit.sv
verif/tb.sv
